@@ rtl/core/diff_hunk_header_parser_defines.svh @@
// ----------------------------------------------------------------------------
// diff hunk header parser assertion macros
// concurrent property wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DIFF_HUNK_HEADER_PARSER_DEFINES_SVH
`define DIFF_HUNK_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define DHHP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dhhp assertion failed");

`define DHHP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dhhp assertion failed");

`else

`define DHHP_ASSERT_IMP(lbl, ante, cons)

`define DHHP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/dhhp_pkg.sv @@
// ----------------------------------------------------------------------------
// dhhp_pkg
// word types, result codes and character constants of the hunk header parser
// ----------------------------------------------------------------------------
package dhhp_pkg;

	localparam int unsigned OUT_W = 31;

	localparam logic [OUT_W-1:0] HUNK_MAX = {OUT_W{1'b1}};

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		KIND_HUNK    = 2'd0,
		KIND_ERROR   = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		EDIT_ADD    = 2'd0,
		EDIT_CHANGE = 2'd1,
		EDIT_DELETE = 2'd2
	} edit_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_t;

	typedef struct packed {
		kind_t            result_kind;
		logic [OUT_W-1:0] from_first;
		logic [OUT_W-1:0] from_last;
		edit_t            edit_kind;
		logic [OUT_W-1:0] to_first;
		logic [OUT_W-1:0] to_last;
		logic [OUT_W-1:0] hunk_total;
	} out_t;

	typedef struct packed {
		logic fire;
		out_t word;
	} result_t;

endpackage

@@ rtl/core/dhhp_parse.sv @@
// ----------------------------------------------------------------------------
// dhhp_parse
// parser state and next-state logic, one byte per step, at most one result
// ----------------------------------------------------------------------------
module dhhp_parse #(
	parameter int unsigned MAX_LINE = 8192,
	parameter int unsigned NUM_BITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dhhp_pkg::in_t       in_word,
	output dhhp_pkg::result_t   result
);

	localparam int unsigned LEN_W = $clog2(MAX_LINE);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE - 1);
	localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

	typedef enum logic [1:0] {PH_LINE, PH_SKIP, PH_NUM, PH_TRAIL} phase_t;
	typedef enum logic [1:0] {SUB_LEAD, SUB_SIGN, SUB_DIGITS} sub_t;
	typedef enum logic [1:0] {
		SLOT_OLD_FIRST, SLOT_OLD_LAST, SLOT_NEW_FIRST, SLOT_NEW_LAST
	} slot_t;

	phase_t                        phase_q, phase_nx;
	sub_t                          sub_q, sub_nx;
	slot_t                         slot_q, slot_nx;
	logic [NUM_BITS-1:0]           acc_q, acc_nx;
	logic [NUM_BITS-1:0]           old_first_q, old_first_nx;
	logic [NUM_BITS-1:0]           old_last_q, old_last_nx;
	logic [NUM_BITS-1:0]           new_first_q, new_first_nx;
	dhhp_pkg::edit_t               op_q, op_nx;
	logic [LEN_W-1:0]              len_q, len_nx;
	logic                          err_q, err_nx;
	logic [dhhp_pkg::OUT_W-1:0]    count_q, count_nx;

	logic [7:0]                    c;
	logic                          is_digit;
	logic                          is_ws;
	logic [NUM_BITS+3:0]           prod;
	logic [LEN_W-1:0]              len_inc;
	logic                          fail;
	logic                          emit;
	logic                          do_letter;
	logic                          do_endline;
	logic [NUM_BITS-1:0]           emit_last;
	logic [63:0]                   w_old_first;
	logic [63:0]                   w_old_last;
	logic [63:0]                   w_new_first;
	logic [63:0]                   w_last;

	assign c        = in_word.in_byte;
	assign is_digit = (c >= dhhp_pkg::CH_ZERO) && (c <= dhhp_pkg::CH_NINE);
	assign is_ws    = (c == dhhp_pkg::CH_SPACE) || (c == dhhp_pkg::CH_TAB)
		|| (c == dhhp_pkg::CH_VT) || (c == dhhp_pkg::CH_FF) || (c == dhhp_pkg::CH_CR);
	assign prod     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ (NUM_BITS+4)'(c[3:0]);
	assign len_inc  = (len_q == LEN_SAT) ? len_q : len_q + 1'b1;

	always_comb begin
		phase_nx     = phase_q;
		sub_nx       = sub_q;
		slot_nx      = slot_q;
		acc_nx       = acc_q;
		old_first_nx = old_first_q;
		old_last_nx  = old_last_q;
		new_first_nx = new_first_q;
		op_nx        = op_q;
		len_nx       = len_q;
		err_nx       = err_q;
		count_nx     = count_q;
		fail         = 1'b0;
		emit         = 1'b0;
		do_letter    = 1'b0;
		do_endline   = 1'b0;
		emit_last    = acc_q;
		result       = '0;

		if (in_word.end_of_stream) begin
			result.fire = 1'b1;
			if (err_q || !(phase_q == PH_LINE || phase_q == PH_SKIP)) begin
				result.word.result_kind = dhhp_pkg::KIND_ERROR;
			end else begin
				result.word.result_kind = dhhp_pkg::KIND_SUMMARY;
				result.word.hunk_total  = count_q;
			end
			phase_nx     = PH_LINE;
			sub_nx       = SUB_LEAD;
			slot_nx      = SLOT_OLD_FIRST;
			acc_nx       = '0;
			old_first_nx = '0;
			old_last_nx  = '0;
			new_first_nx = '0;
			op_nx        = dhhp_pkg::EDIT_ADD;
			len_nx       = '0;
			err_nx       = 1'b0;
			count_nx     = '0;
		end else if (!err_q) begin
			unique case (phase_q)
				PH_LINE: begin
					if (is_digit) begin
						phase_nx = PH_NUM;
						slot_nx  = SLOT_OLD_FIRST;
						sub_nx   = SUB_DIGITS;
						acc_nx   = NUM_BITS'(c[3:0]);
						len_nx   = LEN_W'(1);
					end else if (c != dhhp_pkg::CH_NL) begin
						phase_nx = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (c == dhhp_pkg::CH_NL) begin
						phase_nx = PH_LINE;
					end
				end
				PH_TRAIL, PH_NUM: begin
					len_nx = len_inc;
					if (c != dhhp_pkg::CH_NL && len_inc >= LEN_LIMIT) begin
						fail = 1'b1;
					end else if (phase_q == PH_TRAIL) begin
						if (c == dhhp_pkg::CH_NL) begin
							emit = 1'b1;
						end
					end else if (is_digit) begin
						if (sub_q == SUB_DIGITS) begin
							if (|prod[NUM_BITS+3:NUM_BITS]) begin
								fail = 1'b1;
							end else begin
								acc_nx = prod[NUM_BITS-1:0];
							end
						end else begin
							acc_nx = NUM_BITS'(c[3:0]);
							sub_nx = SUB_DIGITS;
						end
					end else if (sub_q == SUB_DIGITS) begin
						unique case (slot_q)
							SLOT_OLD_FIRST: begin
								old_first_nx = acc_q;
								old_last_nx  = acc_q;
								if (c == dhhp_pkg::CH_COMMA) begin
									slot_nx = SLOT_OLD_LAST;
									sub_nx  = SUB_LEAD;
									acc_nx  = '0;
								end else begin
									do_letter = 1'b1;
								end
							end
							SLOT_OLD_LAST: begin
								if (acc_q < old_first_q) begin
									fail = 1'b1;
								end else begin
									old_last_nx = acc_q;
									do_letter   = 1'b1;
								end
							end
							SLOT_NEW_FIRST: begin
								new_first_nx = acc_q;
								if (c == dhhp_pkg::CH_COMMA) begin
									if (op_q == dhhp_pkg::EDIT_DELETE) begin
										fail = 1'b1;
									end else begin
										slot_nx = SLOT_NEW_LAST;
										sub_nx  = SUB_LEAD;
										acc_nx  = '0;
									end
								end else begin
									do_endline = 1'b1;
								end
							end
							SLOT_NEW_LAST: begin
								if (acc_q < new_first_q) begin
									fail = 1'b1;
								end else begin
									do_endline = 1'b1;
								end
							end
							default: begin
								fail = 1'b1;
							end
						endcase
					end else if (sub_q == SUB_LEAD && is_ws) begin
						phase_nx = PH_NUM;
					end else if (sub_q == SUB_LEAD && c == dhhp_pkg::CH_PLUS) begin
						sub_nx = SUB_SIGN;
					end else begin
						fail = 1'b1;
					end
				end
				default: begin
					fail = 1'b1;
				end
			endcase

			// operation letter after the old range
			if (do_letter) begin
				priority if (c == dhhp_pkg::CH_A && slot_q == SLOT_OLD_LAST) begin
					fail = 1'b1;
				end else if (c == dhhp_pkg::CH_A) begin
					op_nx = dhhp_pkg::EDIT_ADD;
				end else if (c == dhhp_pkg::CH_C) begin
					op_nx = dhhp_pkg::EDIT_CHANGE;
				end else if (c == dhhp_pkg::CH_D) begin
					op_nx = dhhp_pkg::EDIT_DELETE;
				end else begin
					fail = 1'b1;
				end
				if (!fail) begin
					slot_nx = SLOT_NEW_FIRST;
					sub_nx  = SUB_LEAD;
					acc_nx  = '0;
				end
			end

			if (do_endline) begin
				if (c == dhhp_pkg::CH_NL) begin
					emit = 1'b1;
				end else begin
					phase_nx = PH_TRAIL;
				end
			end

			if (fail) begin
				err_nx                  = 1'b1;
				result.fire             = 1'b1;
				result.word.result_kind = dhhp_pkg::KIND_ERROR;
			end else if (emit) begin
				result.fire             = 1'b1;
				result.word.result_kind = dhhp_pkg::KIND_HUNK;
				result.word.from_first  = w_old_first[dhhp_pkg::OUT_W-1:0];
				result.word.from_last   = w_old_last[dhhp_pkg::OUT_W-1:0];
				result.word.edit_kind   = op_nx;
				result.word.to_first    = w_new_first[dhhp_pkg::OUT_W-1:0];
				result.word.to_last     = w_last[dhhp_pkg::OUT_W-1:0];
				phase_nx                = PH_LINE;
				if (count_q != dhhp_pkg::HUNK_MAX) begin
					count_nx = count_q + 1'b1;
				end
			end
		end
	end

	assign w_old_first = 64'(old_first_nx);
	assign w_old_last  = 64'(old_last_nx);
	assign w_new_first = 64'(new_first_nx);
	assign w_last      = 64'(emit_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LINE;
			sub_q       <= SUB_LEAD;
			slot_q      <= SLOT_OLD_FIRST;
			acc_q       <= '0;
			old_first_q <= '0;
			old_last_q  <= '0;
			new_first_q <= '0;
			op_q        <= dhhp_pkg::EDIT_ADD;
			len_q       <= '0;
			err_q       <= 1'b0;
			count_q     <= '0;
		end else if (step) begin
			phase_q     <= phase_nx;
			sub_q       <= sub_nx;
			slot_q      <= slot_nx;
			acc_q       <= acc_nx;
			old_first_q <= old_first_nx;
			old_last_q  <= old_last_nx;
			new_first_q <= new_first_nx;
			op_q        <= op_nx;
			len_q       <= len_nx;
			err_q       <= err_nx;
			count_q     <= count_nx;
		end
	end

endmodule

@@ rtl/core/diff_hunk_header_parser.sv @@
// ----------------------------------------------------------------------------
// diff_hunk_header_parser
// streaming parser for hunk headers of normal-format diff text
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready/in_word carries one text byte per word, or
// an end-of-stream marker; output channel out_valid/out_ready/out_word gives
// a hunk record per valid header line, a single error word for the first bad
// header, and a summary or error word at end of stream.
// a word is held in the input register, is parsed against the current
// state in one pass and its result, if any, lands in the output register,
// from which it drives out_valid and out_word.
// throughput is one word per cycle while the receiver keeps up; the per-byte
// state update is the loop. while the receiver stalls the output register
// holds and the input register keeps one more word, after which in_ready drops.
// reset clears the parser, the hunk count and the error latch; end of stream
// does the same after its result, so a new stream may follow at once.
// ----------------------------------------------------------------------------
`include "diff_hunk_header_parser_defines.svh"

module diff_hunk_header_parser #(
	parameter int unsigned MAX_LINE = 8192,
	parameter int unsigned NUM_BITS = 31
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dhhp_pkg::in_t  in_word,
	output logic           out_valid,
	input  logic           out_ready,
	output dhhp_pkg::out_t out_word
);

	logic               valid_s1;
	dhhp_pkg::in_t      word_s1;
	logic               advance;
	dhhp_pkg::result_t  result;
	logic               out_valid_q;
	dhhp_pkg::out_t     out_word_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	dhhp_parse #(
		.MAX_LINE(MAX_LINE),
		.NUM_BITS(NUM_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.in_word (word_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && result.fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
		if (advance && result.fire) begin
			out_word_q <= result.word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`DHHP_ASSERT_IMP(a_ready_when_empty, !valid_s1, in_ready)
	`DHHP_ASSERT_NXT(a_eos_gives_result, advance && word_s1.end_of_stream, out_valid)
	`DHHP_ASSERT_IMP(a_error_word_clean,
		out_valid && out_word.result_kind == dhhp_pkg::KIND_ERROR,
		out_word.from_first == '0 && out_word.to_last == '0 && out_word.hunk_total == '0)

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb - testbench of diff_hunk_header_parser
// feeds diff text one byte per word, plus end-of-stream markers, through the
// valid/ready input channel. an in-bench copy of the parser predicts the
// record, error or summary word due for each accepted word. each word out is
// checked field by field against the oldest prediction. directed streams
// cover the edge values, every edit kind and each kind of broken header.
// random streams of mostly well-formed headers follow, with text lines and
// broken headers mixed in, under several input idle and output stall patterns
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PH_LINE = 0;
	localparam int unsigned PH_SKIP = 1;
	localparam int unsigned PH_NUM = 2;
	localparam int unsigned PH_TRAIL = 14;
	localparam int unsigned LINE_LIMIT = 8192;
	localparam int unsigned LEN_SAT = 16383;
	localparam longint unsigned NUM_MAX = 64'h7FFF_FFFF;
	localparam int unsigned OW = dhhp_pkg::OUT_W;

	typedef enum int {
		FLAW_NONE,
		FLAW_MINUS,
		FLAW_NO_DIGITS,
		FLAW_OVERFLOW,
		FLAW_LETTER,
		FLAW_ADD_RANGE,
		FLAW_DEL_RANGE,
		FLAW_REVERSED,
		FLAW_NOISE
	} flaw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	dhhp_pkg::in_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	dhhp_pkg::out_t out_word;

	int unsigned in_idle_pct = 0;
	int unsigned out_stall_pct = 0;
	int unsigned fail_count = 0;
	int unsigned live_words = 0;

	// parser state of the prediction
	int unsigned ph;
	longint unsigned acc;
	longint unsigned old_first_q;
	longint unsigned old_last_q;
	longint unsigned new_first_q;
	longint unsigned hunk_cnt;
	dhhp_pkg::edit_t op_q;
	bit rng_q;
	bit err_q;
	int unsigned len_q;
	dhhp_pkg::out_t next_result;
	dhhp_pkg::out_t results_due[$];

	logic [7:0] text_q[$];
	logic [7:0] ws_bytes [5] = '{dhhp_pkg::CH_SPACE, dhhp_pkg::CH_TAB, dhhp_pkg::CH_VT,
		dhhp_pkg::CH_FF, dhhp_pkg::CH_CR};

	diff_hunk_header_parser i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_word,
		.out_valid,
		.out_ready,
		.out_word
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= $urandom_range(99) >= out_stall_pct;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	function automatic void clear_parser();
		ph = PH_LINE;
		acc = 0;
		old_first_q = 0;
		old_last_q = 0;
		new_first_q = 0;
		hunk_cnt = 0;
		op_q = dhhp_pkg::EDIT_ADD;
		rng_q = 1'b0;
		err_q = 1'b0;
		len_q = 0;
	endfunction

	function automatic bit flag_error();
		err_q = 1'b1;
		next_result = '0;
		next_result.result_kind = dhhp_pkg::KIND_ERROR;
		return 1'b1;
	endfunction

	function automatic bit emit_hunk(longint unsigned last);
		next_result = '0;
		next_result.result_kind = dhhp_pkg::KIND_HUNK;
		next_result.from_first = old_first_q[OW-1:0];
		next_result.from_last = old_last_q[OW-1:0];
		next_result.edit_kind = op_q;
		next_result.to_first = new_first_q[OW-1:0];
		next_result.to_last = last[OW-1:0];
		if (hunk_cnt < NUM_MAX) begin
			hunk_cnt++;
		end
		ph = PH_LINE;
		return 1'b1;
	endfunction

	function automatic void enter_slot(int unsigned slot);
		ph = PH_NUM + slot * 3;
		acc = 0;
	endfunction

	function automatic bit parse_word(dhhp_pkg::in_t w);
		logic [7:0] c;
		longint unsigned v;
		longint unsigned d;
		int unsigned slot;
		int unsigned sub;
		c = w.in_byte;
		if (w.end_of_stream) begin
			next_result = '0;
			if (err_q || (ph != PH_LINE && ph != PH_SKIP)) begin
				next_result.result_kind = dhhp_pkg::KIND_ERROR;
			end else begin
				next_result.result_kind = dhhp_pkg::KIND_SUMMARY;
				next_result.hunk_total = hunk_cnt[OW-1:0];
			end
			clear_parser();
			return 1'b1;
		end
		if (err_q) begin
			return 1'b0;
		end
		if (ph == PH_LINE) begin
			if (c >= dhhp_pkg::CH_ZERO && c <= dhhp_pkg::CH_NINE) begin
				ph = PH_NUM + 2;
				acc = c - dhhp_pkg::CH_ZERO;
				len_q = 1;
				rng_q = 1'b0;
			end else if (c != dhhp_pkg::CH_NL) begin
				ph = PH_SKIP;
			end
			return 1'b0;
		end
		if (ph == PH_SKIP) begin
			if (c == dhhp_pkg::CH_NL) begin
				ph = PH_LINE;
			end
			return 1'b0;
		end
		if (len_q < LEN_SAT) begin
			len_q++;
		end
		if (c != dhhp_pkg::CH_NL && len_q >= LINE_LIMIT - 1) begin
			return flag_error();
		end
		if (ph == PH_TRAIL) begin
			if (c == dhhp_pkg::CH_NL) begin
				return emit_hunk(acc);
			end
			return 1'b0;
		end
		slot = (ph - PH_NUM) / 3;
		sub = (ph - PH_NUM) % 3;
		if (c >= dhhp_pkg::CH_ZERO && c <= dhhp_pkg::CH_NINE) begin
			d = c - dhhp_pkg::CH_ZERO;
			if (sub == 2) begin
				if (acc > (NUM_MAX - d) / 10) begin
					return flag_error();
				end
				acc = acc * 10 + d;
			end else begin
				acc = d;
				ph = PH_NUM + slot * 3 + 2;
			end
			return 1'b0;
		end
		if (sub == 0) begin
			if (c inside {dhhp_pkg::CH_SPACE, dhhp_pkg::CH_TAB, dhhp_pkg::CH_VT,
				dhhp_pkg::CH_FF, dhhp_pkg::CH_CR}) begin
				return 1'b0;
			end
			if (c == dhhp_pkg::CH_PLUS) begin
				ph = PH_NUM + slot * 3 + 1;
				return 1'b0;
			end
			return flag_error();
		end
		if (sub == 1) begin
			return flag_error();
		end
		// number complete
		v = acc;
		if (slot == 0) begin
			old_first_q = v;
			old_last_q = v;
			rng_q = 1'b0;
			if (c == dhhp_pkg::CH_COMMA) begin
				enter_slot(1);
				return 1'b0;
			end
		end else if (slot == 1) begin
			if (v < old_first_q) begin
				return flag_error();
			end
			old_last_q = v;
			rng_q = 1'b1;
		end
		if (slot <= 1) begin
			if (c == dhhp_pkg::CH_A) begin
				if (rng_q) begin
					return flag_error();
				end
				op_q = dhhp_pkg::EDIT_ADD;
			end else if (c == dhhp_pkg::CH_C) begin
				op_q = dhhp_pkg::EDIT_CHANGE;
			end else if (c == dhhp_pkg::CH_D) begin
				op_q = dhhp_pkg::EDIT_DELETE;
			end else begin
				return flag_error();
			end
			rng_q = 1'b0;
			enter_slot(2);
			return 1'b0;
		end
		if (slot == 2) begin
			new_first_q = v;
			if (c == dhhp_pkg::CH_COMMA) begin
				if (op_q == dhhp_pkg::EDIT_DELETE) begin
					return flag_error();
				end
				rng_q = 1'b1;
				enter_slot(3);
				return 1'b0;
			end
		end else if (v < new_first_q) begin
			return flag_error();
		end
		if (c == dhhp_pkg::CH_NL) begin
			return emit_hunk(v);
		end
		ph = PH_TRAIL;
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= 50) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	always @(posedge clk) begin : check_words
		dhhp_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word of kind %0d", out_word.result_kind));
			end else begin
				want = results_due.pop_front();
				check_field("result_kind", out_word.result_kind, want.result_kind);
				check_field("from_first", out_word.from_first, want.from_first);
				check_field("from_last", out_word.from_last, want.from_last);
				check_field("edit_kind", out_word.edit_kind, want.edit_kind);
				check_field("to_first", out_word.to_first, want.to_first);
				check_field("to_last", out_word.to_last, want.to_last);
				check_field("hunk_total", out_word.hunk_total, want.hunk_total);
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic send_word(dhhp_pkg::in_t w);
		if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < in_idle_pct) begin
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		live_words += (!err_q || w.end_of_stream);
		if (parse_word(w)) begin
			results_due.push_back(next_result);
		end
	endtask

	task automatic send_text();
		while (text_q.size() != 0) begin
			send_word(dhhp_pkg::in_t'({text_q.pop_front(), 1'b0}));
		end
	endtask

	task automatic send_eos();
		send_word(dhhp_pkg::in_t'({8'($urandom), 1'b1}));
	endtask

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++) begin
			text_q.push_back(s[i]);
		end
	endfunction

	function automatic logic [7:0] any_text_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == dhhp_pkg::CH_NL);
		return b;
	endfunction

	function automatic longint unsigned pick_line_no();
		case ($urandom_range(19))
			0, 1, 2: return longint'($urandom) & NUM_MAX;
			3, 4, 5, 6: return $urandom_range(99999);
			default: return $urandom_range(99);
		endcase
	endfunction

	function automatic longint unsigned range_end(longint unsigned v);
		longint unsigned e;
		e = v + (($urandom_range(3) == 0) ? (longint'($urandom) & NUM_MAX) :
			longint'($urandom_range(20)));
		return (e > NUM_MAX) ? NUM_MAX : e;
	endfunction

	function automatic void put_num(longint unsigned v, bit lead, flaw_t f);
		if (lead) begin
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 2)) text_q.push_back(ws_bytes[$urandom_range(4)]);
			end
			if (f == FLAW_MINUS) begin
				text_q.push_back(dhhp_pkg::CH_MINUS);
			end else if ($urandom_range(3) == 0) begin
				text_q.push_back(dhhp_pkg::CH_PLUS);
			end
		end
		if (f == FLAW_NO_DIGITS) begin
			return;
		end
		if ($urandom_range(7) == 0) begin
			text_q.push_back(dhhp_pkg::CH_ZERO);
		end
		put_str($sformatf("%0d", v));
	endfunction

	function automatic void build_header(flaw_t f);
		dhhp_pkg::edit_t op;
		longint unsigned old_a, old_b, new_a, new_b;
		bit old_rng, new_rng;
		int unsigned hit, base;
		logic [7:0] letter;
		base = text_q.size();
		op = dhhp_pkg::edit_t'($urandom_range(2));
		old_a = pick_line_no();
		old_b = range_end(old_a);
		new_a = pick_line_no();
		new_b = range_end(new_a);
		old_rng = (op != dhhp_pkg::EDIT_ADD) && $urandom_range(1);
		new_rng = (op != dhhp_pkg::EDIT_DELETE) && $urandom_range(1);
		case (f)
			FLAW_ADD_RANGE: begin
				op = dhhp_pkg::EDIT_ADD;
				old_rng = 1'b1;
			end
			FLAW_DEL_RANGE: begin
				op = dhhp_pkg::EDIT_DELETE;
				new_rng = 1'b1;
			end
			FLAW_REVERSED: begin
				if (op == dhhp_pkg::EDIT_ADD ||
					(op == dhhp_pkg::EDIT_CHANGE && $urandom_range(1))) begin
					new_rng = 1'b1;
					new_a = $urandom_range(1, 99999);
					new_b = $urandom_range(new_a - 1);
				end else begin
					old_rng = 1'b1;
					old_a = $urandom_range(1, 99999);
					old_b = $urandom_range(old_a - 1);
				end
			end
			FLAW_OVERFLOW: begin
				if ($urandom_range(1)) begin
					old_a = NUM_MAX + 1 + (($urandom_range(3) == 0) ? 0 : longint'($urandom));
				end else begin
					new_a = NUM_MAX + 1 + (($urandom_range(3) == 0) ? 0 : longint'($urandom));
				end
			end
			default: ;
		endcase
		hit = 2;
		if (old_rng && $urandom_range(2) == 0) begin
			hit = 1;
		end else if (new_rng && $urandom_range(1)) begin
			hit = 3;
		end
		put_num(old_a, 1'b0, FLAW_NONE);
		if (old_rng) begin
			text_q.push_back(dhhp_pkg::CH_COMMA);
			put_num(old_b, 1'b1, (hit == 1) ? f : FLAW_NONE);
		end
		letter = (op == dhhp_pkg::EDIT_ADD) ? dhhp_pkg::CH_A :
			(op == dhhp_pkg::EDIT_CHANGE) ? dhhp_pkg::CH_C : dhhp_pkg::CH_D;
		if (f == FLAW_LETTER) begin
			do letter = 8'($urandom);
			while (letter inside {dhhp_pkg::CH_A, dhhp_pkg::CH_C, dhhp_pkg::CH_D,
				dhhp_pkg::CH_COMMA} ||
				(letter >= dhhp_pkg::CH_ZERO && letter <= dhhp_pkg::CH_NINE));
		end
		text_q.push_back(letter);
		put_num(new_a, 1'b1, (hit == 2) ? f : FLAW_NONE);
		if (new_rng) begin
			text_q.push_back(dhhp_pkg::CH_COMMA);
			put_num(new_b, 1'b1, (hit == 3) ? f : FLAW_NONE);
		end
		// trailing junk after the last number
		if ($urandom_range(3) == 0) begin
			text_q.push_back(dhhp_pkg::CH_SPACE);
			repeat ($urandom_range(6)) text_q.push_back(any_text_byte());
		end
		text_q.push_back(dhhp_pkg::CH_NL);
		if (f == FLAW_NOISE) begin
			text_q[base + $urandom_range(text_q.size() - 1 - base)] = 8'($urandom);
		end
	endfunction

	function automatic void build_text_line();
		logic [7:0] b;
		if ($urandom_range(5) != 0) begin
			do b = 8'($urandom);
			while (b == dhhp_pkg::CH_NL ||
				(b >= dhhp_pkg::CH_ZERO && b <= dhhp_pkg::CH_NINE));
			text_q.push_back(b);
			repeat ($urandom_range(12)) text_q.push_back(any_text_byte());
		end
		text_q.push_back(dhhp_pkg::CH_NL);
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_extremes();
		in_idle_pct = 0;
		out_stall_pct = 0;
		send_eos();
		put_str("\n0a0\n2147483647,2147483647c2147483647,2147483647\n");
		text_q.push_back(8'hFF);
		text_q.push_back(8'h00);
		text_q.push_back(dhhp_pkg::CH_NL);
		send_text();
		send_eos();
		send_eos();
	endtask

	task automatic test_edit_kinds();
		put_str("3a4,6\n2,5c7\n8,9d7\n1c2, \t+3 junk\n");
		send_text();
		send_eos();
	endtask

	task automatic test_broken_headers();
		for (int f = FLAW_MINUS; f <= FLAW_NOISE; f++) begin
			build_header(flaw_t'(f));
			put_str("1a1\n");
			send_text();
			send_eos();
		end
		// header still open at end of stream
		put_str("1d2");
		send_text();
		send_eos();
	endtask

	task automatic test_random_streams(int unsigned idle_pct, int unsigned stall_pct,
		int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		in_idle_pct = idle_pct;
		out_stall_pct = stall_pct;
		stop_at = live_words + count;
		while (live_words < stop_at) begin
			repeat ($urandom_range(1, 8)) begin
				pick = $urandom_range(99);
				if (pick < 78) begin
					build_header(FLAW_NONE);
				end else if (pick < 90) begin
					build_text_line();
				end else begin
					build_header(flaw_t'($urandom_range(FLAW_MINUS, FLAW_NOISE)));
				end
			end
			if ($urandom_range(19) == 0) begin
				build_header(FLAW_NONE);
				void'(text_q.pop_back());
			end
			send_text();
			send_eos();
		end
	endtask

	initial begin
		clear_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_edit_kinds();
		test_broken_headers();
		test_random_streams(0, 0, 300);
		test_random_streams(73, 0, 300);
		test_random_streams(0, 73, 300);
		test_random_streams(6, 6, 300);
		in_valid <= 1'b0;
		for (int i = 0; i < 20000 && results_due.size() != 0; i++) begin
			@(posedge clk);
		end
		if (results_due.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", results_due.size()));
		end
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
